// ===== sv/rr_srtf_process_scheduler_core_macros.svh =====
// Assertion macros used by the scheduler sequencer.
`ifndef RR_SRTF_PROCESS_SCHEDULER_CORE_MACROS_SVH
`define RR_SRTF_PROCESS_SCHEDULER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRS_ASSERT(label, prop, msg)
`define RRS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/rrs_pkg.sv =====
// Shared constants and types of the process scheduler.
package rrs_pkg;
    localparam int MAX_SLOTS_DEF  = 16;
    localparam int BURST_BITS_DEF = 16;

    localparam int SLOT_FW  = 4;
    localparam int LEFT_FW  = 16;
    localparam int CFG_DW   = 8;

    typedef logic [1:0] status_t;

    localparam status_t ST_EMPTY    = 2'd0;
    localparam status_t ST_READY    = 2'd1;
    localparam status_t ST_RUNNING  = 2'd2;
    localparam status_t ST_FINISHED = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    localparam logic POLICY_RR   = 1'b0;
    localparam logic POLICY_SRTF = 1'b1;

    localparam logic [CFG_DW-1:0] QUANTUM_RST = 8'd3;
endpackage

// ===== sv/rrs_if.sv =====
// Input and result channel interfaces of the process scheduler.
interface rrs_in_if import rrs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] burst_time;

    modport source (output valid, cmd, burst_time, input ready);
    modport sink (input valid, cmd, burst_time, output ready);
endinterface

interface rrs_out_if import rrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SLOT_FW-1:0] added_slot;
    logic               add_refused;
    logic               running_valid;
    logic [SLOT_FW-1:0] running_slot;
    logic [LEFT_FW-1:0] running_left;
    logic               finished_valid;
    logic [SLOT_FW-1:0] finished_slot;
    logic               switched;

    modport source (output valid, added_slot, add_refused, running_valid, running_slot,
                    running_left, finished_valid, finished_slot, switched, input ready);
    modport sink (input valid, added_slot, add_refused, running_valid, running_slot,
                  running_left, finished_valid, finished_slot, switched, output ready);
endinterface

// ===== sv/rrs_cell.sv =====
// One slot cell of the rotating slot ring: status and remaining burst.
module rrs_cell import rrs_pkg::*; #(
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  status_t               in_status,
    input  logic [BURST_BITS-1:0] in_left,
    output status_t               status,
    output logic [BURST_BITS-1:0] left
);
    status_t               status_reg;
    logic [BURST_BITS-1:0] left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_EMPTY;
        end
        else if (shift)
        begin
            status_reg <= in_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            left_reg <= in_left;
        end
    end

    assign status = status_reg;
    assign left   = left_reg;
endmodule

// ===== sv/rrs_ctrl.sv =====
// Scheduler sequencer: watches the head of the slot ring and drives its tail.
`include "rr_srtf_process_scheduler_core_macros.svh"
module rrs_ctrl import rrs_pkg::*; #(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rrs_in_if.sink                in_ch,
    rrs_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    output logic                  shift,
    input  status_t               head_status,
    input  logic [BURST_BITS-1:0] head_left,
    output status_t               tail_status,
    output logic [BURST_BITS-1:0] tail_left
);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_SEL1 = 3'd2;
    localparam logic [2:0] S_CHG  = 3'd3;
    localparam logic [2:0] S_SEL2 = 3'd4;
    localparam logic [2:0] S_MARK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [SW-1:0]         idx_reg, idx_next;
    logic                  policy_reg, policy_next;
    logic [CFG_DW-1:0]     quantum_reg, quantum_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         rp_reg, rp_next;
    logic                  act_v_reg, act_v_next;
    logic [SW-1:0]         act_s_reg, act_s_next;
    logic [BURST_BITS-1:0] act_left_reg, act_left_next;
    logic [7:0]            slice_reg, slice_next;
    logic                  ret_reg, ret_next;
    logic [BURST_BITS-1:0] burst_reg, burst_next;
    logic                  hi_f_reg, hi_f_next;
    logic [SW-1:0]         hi_s_reg, hi_s_next;
    logic [BURST_BITS-1:0] hi_l_reg, hi_l_next;
    logic                  lo_f_reg, lo_f_next;
    logic [SW-1:0]         lo_s_reg, lo_s_next;
    logic [BURST_BITS-1:0] lo_l_reg, lo_l_next;
    logic [SW-1:0]         added_reg, added_next;
    logic                  refused_reg, refused_next;
    logic                  fin_v_reg, fin_v_next;
    logic [SW-1:0]         fin_s_reg, fin_s_next;
    logic                  sw_reg, sw_next;
    logic                  ov_reg, ov_next;
    logic [SLOT_FW-1:0]    o_added_reg, o_added_next;
    logic                  o_ref_reg, o_ref_next;
    logic                  o_rv_reg, o_rv_next;
    logic [SLOT_FW-1:0]    o_rs_reg, o_rs_next;
    logic [LEFT_FW-1:0]    o_rl_reg, o_rl_next;
    logic                  o_fv_reg, o_fv_next;
    logic [SLOT_FW-1:0]    o_fs_reg, o_fs_next;
    logic                  o_sw_reg, o_sw_next;

    logic is_last;
    logic at_act;
    logic in_fire;

    assign is_last = (idx_reg == SW'(MAX_SLOTS - 1));
    assign at_act  = (idx_reg == act_s_reg);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;

    always_comb
    begin
        status_t               eff;
        logic [BURST_BITS-1:0] newl;
        logic [7:0]            slice_inc;
        logic [SW-1:0]         pick;
        logic [BURST_BITS-1:0] pick_l;
        logic                  found;
        logic [CW-1:0]         cnt_inc;

        state_next    = state_reg;
        idx_next      = idx_reg;
        policy_next   = policy_reg;
        quantum_next  = quantum_reg;
        count_next    = count_reg;
        rp_next       = rp_reg;
        act_v_next    = act_v_reg;
        act_s_next    = act_s_reg;
        act_left_next = act_left_reg;
        slice_next    = slice_reg;
        ret_next      = ret_reg;
        burst_next    = burst_reg;
        hi_f_next     = hi_f_reg;
        hi_s_next     = hi_s_reg;
        hi_l_next     = hi_l_reg;
        lo_f_next     = lo_f_reg;
        lo_s_next     = lo_s_reg;
        lo_l_next     = lo_l_reg;
        added_next    = added_reg;
        refused_next  = refused_reg;
        fin_v_next    = fin_v_reg;
        fin_s_next    = fin_s_reg;
        sw_next       = sw_reg;
        ov_next       = ov_reg;
        o_added_next  = o_added_reg;
        o_ref_next    = o_ref_reg;
        o_rv_next     = o_rv_reg;
        o_rs_next     = o_rs_reg;
        o_rl_next     = o_rl_reg;
        o_fv_next     = o_fv_reg;
        o_fs_next     = o_fs_reg;
        o_sw_next     = o_sw_reg;
        shift         = 1'b0;
        tail_status   = head_status;
        tail_left     = head_left;
        eff           = head_status;
        newl          = '0;
        slice_inc     = (slice_reg == 8'hFF) ? slice_reg : slice_reg + 8'd1;
        pick          = '0;
        pick_l        = '0;
        found         = 1'b0;
        cnt_inc       = '0;

        if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY:  policy_next  = cfg_data[0];
                REG_QUANTUM: quantum_next = cfg_data;
                default:     policy_next  = policy_reg;
            endcase
        end

        // Every pass is one full turn of the ring, so it ends aligned again.
        if (state_reg != S_IDLE && state_reg != S_DONE)
        begin
            shift    = 1'b1;
            idx_next = is_last ? '0 : idx_reg + SW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    added_next   = '0;
                    refused_next = 1'b0;
                    fin_v_next   = 1'b0;
                    fin_s_next   = '0;
                    sw_next      = 1'b0;
                    hi_f_next    = 1'b0;
                    lo_f_next    = 1'b0;
                    burst_next   = BURST_BITS'(in_ch.burst_time);
                    if (in_ch.cmd == CMD_ADD)
                    begin
                        if (count_reg == CW'(MAX_SLOTS))
                        begin
                            refused_next = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ADD;
                        end
                    end
                    else if (act_v_reg)
                    begin
                        state_next = S_CHG;
                    end
                    else
                    begin
                        ret_next   = 1'b0;
                        slice_next = '0;
                        state_next = S_SEL1;
                    end
                end
            end
            S_ADD:
            begin
                if (CW'(idx_reg) == count_reg)
                begin
                    tail_status = ST_READY;
                    tail_left   = burst_reg;
                end
                if (is_last)
                begin
                    added_next = SW'(count_reg);
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SEL1, S_SEL2:
            begin
                // A returning process counts as ready again in this same scan.
                if (ret_reg && at_act && head_status == ST_RUNNING)
                begin
                    eff = ST_READY;
                end
                tail_status = eff;
                if (eff == ST_READY)
                begin
                    if (!lo_f_reg || (policy_reg == POLICY_SRTF && head_left < lo_l_reg))
                    begin
                        lo_f_next = 1'b1;
                        lo_s_next = idx_reg;
                        lo_l_next = head_left;
                    end
                    if (policy_reg == POLICY_RR && !hi_f_reg && idx_reg >= rp_reg)
                    begin
                        hi_f_next = 1'b1;
                        hi_s_next = idx_reg;
                        hi_l_next = head_left;
                    end
                end
                if (is_last)
                begin
                    found  = hi_f_next || lo_f_next;
                    pick   = hi_f_next ? hi_s_next : lo_s_next;
                    pick_l = hi_f_next ? hi_l_next : lo_l_next;
                    act_v_next    = found;
                    act_s_next    = found ? pick : '0;
                    act_left_next = pick_l;
                    sw_next       = sw_reg || ret_reg || found;
                    ret_next      = 1'b0;
                    if (found && policy_reg == POLICY_RR)
                    begin
                        cnt_inc = CW'(pick) + CW'(1);
                        rp_next = (cnt_inc == count_reg) ? '0 : SW'(cnt_inc);
                    end
                    hi_f_next = 1'b0;
                    lo_f_next = 1'b0;
                    if (!found)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = (state_reg == S_SEL1) ? S_CHG : S_MARK;
                    end
                end
            end
            S_CHG:
            begin
                if (at_act)
                begin
                    newl          = (head_left == '0) ? '0 : head_left - BURST_BITS'(1);
                    tail_left     = newl;
                    tail_status   = (newl == '0) ? ST_FINISHED : ST_RUNNING;
                    act_left_next = newl;
                end
                else if (head_status == ST_READY && (!lo_f_reg || head_left < lo_l_reg))
                begin
                    lo_f_next = 1'b1;
                    lo_l_next = head_left;
                end
                if (is_last)
                begin
                    hi_f_next = 1'b0;
                    if (act_left_next == '0)
                    begin
                        fin_v_next    = 1'b1;
                        fin_s_next    = act_s_reg;
                        act_v_next    = 1'b0;
                        act_s_next    = '0;
                        slice_next    = '0;
                        ret_next      = 1'b0;
                        lo_f_next     = 1'b0;
                        state_next    = S_SEL2;
                    end
                    else if (policy_reg == POLICY_RR)
                    begin
                        lo_f_next = 1'b0;
                        if (slice_inc >= quantum_reg)
                        begin
                            slice_next = '0;
                            ret_next   = 1'b1;
                            state_next = S_SEL2;
                        end
                        else
                        begin
                            slice_next = slice_inc;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        slice_next = slice_inc;
                        if (lo_f_next && lo_l_next < act_left_next)
                        begin
                            ret_next   = 1'b1;
                            state_next = S_SEL2;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                        lo_f_next  = 1'b0;
                    end
                end
            end
            S_MARK:
            begin
                if (at_act)
                begin
                    tail_status = ST_RUNNING;
                end
                if (is_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next      = 1'b1;
                    o_added_next = SLOT_FW'(added_reg);
                    o_ref_next   = refused_reg;
                    o_rv_next    = act_v_reg;
                    o_rs_next    = act_v_reg ? SLOT_FW'(act_s_reg) : '0;
                    o_rl_next    = act_v_reg ? LEFT_FW'(act_left_reg) : '0;
                    o_fv_next    = fin_v_reg;
                    o_fs_next    = SLOT_FW'(fin_s_reg);
                    o_sw_next    = sw_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            policy_reg  <= POLICY_RR;
            quantum_reg <= QUANTUM_RST;
            count_reg   <= '0;
            rp_reg      <= '0;
            act_v_reg   <= 1'b0;
            act_s_reg   <= '0;
            slice_reg   <= '0;
            ret_reg     <= 1'b0;
            hi_f_reg    <= 1'b0;
            lo_f_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            policy_reg  <= policy_next;
            quantum_reg <= quantum_next;
            count_reg   <= count_next;
            rp_reg      <= rp_next;
            act_v_reg   <= act_v_next;
            act_s_reg   <= act_s_next;
            slice_reg   <= slice_next;
            ret_reg     <= ret_next;
            hi_f_reg    <= hi_f_next;
            lo_f_reg    <= lo_f_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_left_reg <= act_left_next;
        burst_reg    <= burst_next;
        hi_s_reg     <= hi_s_next;
        hi_l_reg     <= hi_l_next;
        lo_s_reg     <= lo_s_next;
        lo_l_reg     <= lo_l_next;
        added_reg    <= added_next;
        refused_reg  <= refused_next;
        fin_v_reg    <= fin_v_next;
        fin_s_reg    <= fin_s_next;
        sw_reg       <= sw_next;
        o_added_reg  <= o_added_next;
        o_ref_reg    <= o_ref_next;
        o_rv_reg     <= o_rv_next;
        o_rs_reg     <= o_rs_next;
        o_rl_reg     <= o_rl_next;
        o_fv_reg     <= o_fv_next;
        o_fs_reg     <= o_fs_next;
        o_sw_reg     <= o_sw_next;
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.added_slot     = o_added_reg;
    assign out_ch.add_refused    = o_ref_reg;
    assign out_ch.running_valid  = o_rv_reg;
    assign out_ch.running_slot   = o_rs_reg;
    assign out_ch.running_left   = o_rl_reg;
    assign out_ch.finished_valid = o_fv_reg;
    assign out_ch.finished_slot  = o_fs_reg;
    assign out_ch.switched       = o_sw_reg;

    `RRS_ASSERT(a_count_range, count_reg <= CW'(MAX_SLOTS), "slot count beyond table size")
    `RRS_ASSERT(a_ring_aligned, (state_reg != S_IDLE) || (idx_reg == '0), "ring misaligned at rest")
    `RRS_ASSERT(a_idle_slot_zero, act_v_reg || (act_s_reg == '0), "idle active slot not cleared")
    `RRS_ASSERT(a_pointer_range, (CW'(rp_reg) < count_reg) || (rp_reg == '0), "bad rotate pointer")
    `RRS_ASSERT_NEXT(a_accept_busy, in_fire, state_reg != S_IDLE, "accept did not start work")
endmodule

// ===== sv/rr_srtf_process_scheduler_core.sv =====
// Top level of the round robin / SRTF process scheduler: slot ring and sequencer.
//
//   channel   direction  payload
//   in_ch     in         cmd, burst_time
//   out_ch    out        added_slot, add_refused, running_*, finished_*, switched
//   cfg_*     in         write enable, register index, 8-bit data
//
// Slot state lives in a ring of MAX_SLOTS cells that turns one slot per cycle
// during a pass. An add takes one turn; a tick takes one turn per pass, up to
// four passes (select, charge, reselect, mark). A refused add skips the ring.
// Reset clears all slot status at once.
// A finished item waits in the result register while the next item is taken.
module rr_srtf_process_scheduler_core import rrs_pkg::*; #(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    rrs_in_if.sink            in_ch,
    rrs_out_if.source         out_ch,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);
    logic                  shift;
    status_t               tail_status;
    logic [BURST_BITS-1:0] tail_left;
    status_t               ring_status [MAX_SLOTS];
    logic [BURST_BITS-1:0] ring_left [MAX_SLOTS];

    rrs_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .BURST_BITS (BURST_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .shift       (shift),
        .head_status (ring_status[0]),
        .head_left   (ring_left[0]),
        .tail_status (tail_status),
        .tail_left   (tail_left)
    );

    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        if (i == MAX_SLOTS - 1)
        begin : g_tail
            rrs_cell #(.BURST_BITS(BURST_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .in_status (tail_status),
                .in_left   (tail_left),
                .status    (ring_status[i]),
                .left      (ring_left[i])
            );
        end
        else
        begin : g_mid
            rrs_cell #(.BURST_BITS(BURST_BITS)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .in_status (ring_status[i+1]),
                .in_left   (ring_left[i+1]),
                .status    (ring_status[i]),
                .left      (ring_left[i])
            );
        end
    end
endmodule

// ===== tb/rr_srtf_process_scheduler_core_tb.sv =====
// Self-checking testbench for the round robin / SRTF process scheduler core.
module rr_srtf_process_scheduler_core_tb;
    import rrs_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [15:0] burst_time;
    } sched_req_t;

    typedef struct packed {
        logic [3:0]  added_slot;
        logic        add_refused;
        logic        running_valid;
        logic [3:0]  running_slot;
        logic [15:0] running_left;
        logic        finished_valid;
        logic [3:0]  finished_slot;
        logic        switched;
    } sched_resp_t;

    localparam int NSLOTS = 16;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    rrs_in_if in_ch ();
    rrs_out_if out_ch ();

    rr_srtf_process_scheduler_core DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Scoreboard copy of the scheduler state.
    logic        pol = POLICY_RR;
    logic [7:0]  quantum = QUANTUM_RST;
    status_t     status_tbl [NSLOTS] = '{default: ST_EMPTY};
    logic [15:0] left_tbl  [NSLOTS] = '{default: 16'd0};
    int          filled = 0;
    int          rot_ptr = 0;
    logic        run_v = 1'b0;
    int          run_slot = 0;
    int          slice_cnt = 0;

    sched_req_t  pending_reqs [$];
    sched_resp_t expected_resps [$];
    int  errors = 0;
    bit  in_fired;
    bit  hold_req = 1'b0;
    bit  hold_done;
    int  hold_left;
    int  rx_wait;
    int  tx_wait;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit select_ready(output int pick);
        int idx;
        int best_left;
        bit found;
        found = 0;
        pick = 0;
        best_left = 0;
        if (filled == 0)
            return 0;
        if (pol == POLICY_RR)
        begin
            for (int i = 0; i < filled; i++)
            begin
                idx = (rot_ptr + i) % filled;
                if (status_tbl[idx] == ST_READY)
                begin
                    rot_ptr = (idx + 1) % filled;
                    pick = idx;
                    return 1;
                end
            end
            return 0;
        end
        for (int i = 0; i < filled; i++)
        begin
            if (status_tbl[i] == ST_READY && (!found || left_tbl[i] < best_left))
            begin
                found = 1;
                pick = i;
                best_left = left_tbl[i];
            end
        end
        return found;
    endfunction

    function automatic logic swap_process();
        int pick;
        logic moved;
        moved = 0;
        if (run_v)
        begin
            if (status_tbl[run_slot] == ST_RUNNING)
                status_tbl[run_slot] = ST_READY;
            moved = 1;
        end
        run_v = 0;
        run_slot = 0;
        if (select_ready(pick))
        begin
            run_v = 1;
            run_slot = pick;
            status_tbl[pick] = ST_RUNNING;
            moved = 1;
        end
        return moved;
    endfunction

    function automatic sched_resp_t schedule_step(sched_req_t req);
        sched_resp_t r;
        int a;
        bit found;
        logic [15:0] best_left;
        r = '0;
        if (req.cmd == CMD_ADD)
        begin
            if (filled < NSLOTS)
            begin
                r.added_slot = filled[3:0];
                status_tbl[filled] = ST_READY;
                left_tbl[filled] = req.burst_time;
                filled++;
            end
            else
                r.add_refused = 1;
        end
        else
        begin
            if (!run_v)
            begin
                r.switched |= swap_process();
                slice_cnt = 0;
            end
            if (run_v)
            begin
                a = run_slot;
                if (left_tbl[a] > 0)
                    left_tbl[a]--;
                if (slice_cnt < 255)
                    slice_cnt++;
                if (left_tbl[a] == 0)
                begin
                    status_tbl[a] = ST_FINISHED;
                    run_v = 0;
                    run_slot = 0;
                    slice_cnt = 0;
                    r.finished_valid = 1;
                    r.finished_slot = a[3:0];
                    r.switched |= swap_process();
                end
                else if (pol == POLICY_RR)
                begin
                    if (slice_cnt >= quantum)
                    begin
                        slice_cnt = 0;
                        r.switched |= swap_process();
                    end
                end
                else
                begin
                    found = 0;
                    best_left = 0;
                    for (int i = 0; i < filled; i++)
                    begin
                        if (status_tbl[i] == ST_READY && (!found || left_tbl[i] < best_left))
                        begin
                            found = 1;
                            best_left = left_tbl[i];
                        end
                    end
                    if (found && best_left < left_tbl[a])
                        r.switched |= swap_process();
                end
            end
        end
        r.running_valid = run_v;
        r.running_slot = run_v ? run_slot[3:0] : 4'd0;
        r.running_left = run_v ? left_tbl[run_slot] : 16'd0;
        return r;
    endfunction

    function automatic sched_req_t make_req(logic c, logic [15:0] b);
        sched_req_t q;
        q.cmd = c;
        q.burst_time = b;
        return q;
    endfunction

    task automatic queue_req(input sched_req_t req);
        pending_reqs = {pending_reqs, req};
    endtask

    // Driver: presents queued items with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.cmd <= CMD_TICK;
            in_ch.burst_time <= '0;
            tx_wait <= 0;
        end
        else if (!in_ch.valid || in_fired)
        begin
            if (tx_wait > 0)
            begin
                tx_wait <= tx_wait - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.cmd <= pending_reqs[0].cmd;
                in_ch.burst_time <= pending_reqs[0].burst_time;
                void'(pending_reqs.pop_front());
                tx_wait <= $urandom_range(0, 4);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Predict at acceptance.
    always @(posedge clk)
    begin
        in_fired <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_resps = {expected_resps,
                              schedule_step(make_req(in_ch.cmd, in_ch.burst_time))};
    end

    // Receiver stall control; a long hold-off runs in its own counter.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b1;
            rx_wait = 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            rx_wait = $urandom_range(0, 4);
            out_ch.ready <= (rx_wait == 0);
        end
        else if (!out_ch.ready)
        begin
            if (rx_wait > 0)
                rx_wait--;
            out_ch.ready <= (rx_wait == 0);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge clk)
    begin
        sched_resp_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_resps.size() == 0)
            begin
                $error("result with no expectation waiting");
                errors++;
            end
            else
            begin
                exp_r = expected_resps.pop_front();
                if (out_ch.added_slot !== exp_r.added_slot)
                begin
                    $error("added_slot exp %0d got %0d", exp_r.added_slot, out_ch.added_slot);
                    errors++;
                end
                if (out_ch.add_refused !== exp_r.add_refused)
                begin
                    $error("add_refused exp %0d got %0d", exp_r.add_refused,
                           out_ch.add_refused);
                    errors++;
                end
                if (out_ch.running_valid !== exp_r.running_valid)
                begin
                    $error("running_valid exp %0d got %0d", exp_r.running_valid,
                           out_ch.running_valid);
                    errors++;
                end
                if (out_ch.running_slot !== exp_r.running_slot)
                begin
                    $error("running_slot exp %0d got %0d", exp_r.running_slot,
                           out_ch.running_slot);
                    errors++;
                end
                if (out_ch.running_left !== exp_r.running_left)
                begin
                    $error("running_left exp %0d got %0d", exp_r.running_left,
                           out_ch.running_left);
                    errors++;
                end
                if (out_ch.finished_valid !== exp_r.finished_valid)
                begin
                    $error("finished_valid exp %0d got %0d", exp_r.finished_valid,
                           out_ch.finished_valid);
                    errors++;
                end
                if (out_ch.finished_slot !== exp_r.finished_slot)
                begin
                    $error("finished_slot exp %0d got %0d", exp_r.finished_slot,
                           out_ch.finished_slot);
                    errors++;
                end
                if (out_ch.switched !== exp_r.switched)
                begin
                    $error("switched exp %0d got %0d", exp_r.switched, out_ch.switched);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_POLICY)
            pol = val[0];
        else
            quantum = val;
    endtask

    // Checked at the rising edge, where the driver never changes anything.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_resps.size() > 0)
            @(posedge clk);
        repeat (80) @(negedge clk);
    endtask

    // A workload is a batch of adds followed by ticks; short bursts make
    // processes finish, so ticks keep producing activity.
    task automatic queue_workload(input int n_add, input int n_tick);
        logic [15:0] b;
        for (int i = 0; i < n_add; i++)
        begin
            case ($urandom_range(0, 9))
                0: b = 16'($urandom);
                1: b = 16'hFFFF;
                2: b = 16'd0;
                default: b = 16'($urandom_range(0, 12));
            endcase
            queue_req(make_req(CMD_ADD, b));
        end
        for (int i = 0; i < n_tick; i++)
            queue_req(make_req(CMD_TICK, 16'($urandom)));
    endtask

    // Only reset clears the fill count, and the block is reset once, so later
    // phases reuse the filled table.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick, zero burst, extreme bursts, then an SRTF round.
        queue_req(make_req(CMD_TICK, 16'hFFFF));
        queue_req(make_req(CMD_ADD, 16'd0));
        queue_req(make_req(CMD_TICK, 16'd0));
        queue_req(make_req(CMD_TICK, 16'd0));
        queue_req(make_req(CMD_ADD, 16'd2));
        queue_req(make_req(CMD_ADD, 16'd5));
        queue_req(make_req(CMD_ADD, 16'hFFFF));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(CMD_TICK, 16'h5555));
        wait_drained();
        write_reg(REG_POLICY, 8'(POLICY_SRTF));
        queue_req(make_req(CMD_ADD, 16'd1));
        queue_req(make_req(CMD_TICK, 16'hAAAA));
        queue_req(make_req(CMD_ADD, 16'd3));
        queue_req(make_req(CMD_ADD, 16'd3));
        queue_req(make_req(CMD_TICK, 16'd0));
        queue_req(make_req(CMD_TICK, 16'd0));
        wait_drained();

        // Random phases with varied policy and quantum, including extremes.
        for (int ph = 0; ph < 22; ph++)
        begin
            write_reg(REG_POLICY, 8'($urandom_range(0, 1)));
            case (ph % 4)
                0: write_reg(REG_QUANTUM, 8'd1);
                1: write_reg(REG_QUANTUM, 8'd255);
                2: write_reg(REG_QUANTUM, 8'd0);
                default: write_reg(REG_QUANTUM, 8'($urandom_range(1, 6)));
            endcase
            if (ph == 5)
                hold_req = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                queue_workload($urandom_range(0, 4), $urandom_range(5, 25));
                if ($urandom_range(0, 3) == 0)
                    queue_req(make_req(1'($urandom_range(0, 1)), 16'($urandom)));
            end
            wait_drained();
        end
        if (errors == 0)
            $display("rr_srtf_process_scheduler_core test passed");
        else
            $display("rr_srtf_process_scheduler_core test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("rr_srtf_process_scheduler_core test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/rrs_pkg.sv
sv/rrs_if.sv
sv/rrs_cell.sv
sv/rrs_ctrl.sv
sv/rr_srtf_process_scheduler_core.sv
tb/rr_srtf_process_scheduler_core_tb.sv
